// ===== src/gfmmt_pkg.sv =====
// Package for the grouped fitness min/max tracker: sizes, register indexes,
// record kinds and the output record type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gfmmt_pkg;

    // population limits
    localparam int MAX_GROUPS = 16;
    localparam int MAX_AGENTS = 1024;

    // field and counter widths
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 14;
    localparam int GROUP_W     = 4;
    localparam int AGENT_W     = 10;
    localparam int GROUPS_REG_W = 5;
    localparam int AGENTS_REG_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;

    // output queue
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GROUPS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGENTS_IN_USE = 1'd1;

    typedef enum logic {
        KIND_GROUP  = 1'b0,
        KIND_GLOBAL = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [GROUP_W-1:0]  group;
        logic [INDEX_W-1:0]  hi_idx;
        logic [VALUE_W-1:0]  hi_val;
        logic [INDEX_W-1:0]  lo_idx;
        logic [VALUE_W-1:0]  lo_val;
        logic                last;
    } t_record;

endpackage
`default_nettype wire

// ===== src/grouped_fitness_min_max_tracker.sv =====
// Grouped fitness min/max tracker, top level.
// Depends on gfmmt_pkg for sizes, register indexes and the record type.
//
// Takes one signed Q16.16 fitness word per ready cycle, group by group, and keeps
// the highest and lowest value of each group with the global agent index of
// each (first occurrence wins ties). At a group's last agent a group record
// is queued; after the last group of a round a global record follows it.
// Both records are formed in the accepting cycle and land in a 4-word output
// queue register, whose head word drives the output ports. Input ready stays
// high while the queue holds at most two words, so with a draining output the
// block takes one word every cycle as long as it makes no more than one record
// per word on average; a round of a single one-agent group makes two records
// per word, so the queue fills and input ready drops between words. A stalled
// output stops input once three or more records wait. Any register write
// restarts the round at group 0, agent 0, index 0.
`timescale 1ns / 1ps
`default_nettype none
module grouped_fitness_min_max_tracker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [gfmmt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gfmmt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic signed [gfmmt_pkg::VALUE_W-1:0]  i_fitness_value,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_record_kind,
    output logic [gfmmt_pkg::GROUP_W-1:0]              o_group_number,
    output logic [gfmmt_pkg::INDEX_W-1:0]              o_highest_index,
    output logic signed [gfmmt_pkg::VALUE_W-1:0]       o_highest_value,
    output logic [gfmmt_pkg::INDEX_W-1:0]              o_lowest_index,
    output logic signed [gfmmt_pkg::VALUE_W-1:0]       o_lowest_value,
    output logic                                       o_last_of_run
);

    localparam int VW = gfmmt_pkg::VALUE_W;
    localparam int IW = gfmmt_pkg::INDEX_W;
    localparam int GW = gfmmt_pkg::GROUP_W;
    localparam int AW = gfmmt_pkg::AGENT_W;
    localparam int GRW = gfmmt_pkg::GROUPS_REG_W;
    localparam int ARW = gfmmt_pkg::AGENTS_REG_W;
    localparam int QAW = gfmmt_pkg::QUEUE_AW;
    localparam int QD  = gfmmt_pkg::QUEUE_DEPTH;

    // configuration registers (held already clamped)
    logic [GRW-1:0] r_groups;
    logic [ARW-1:0] r_agents;
    logic [GRW-1:0] n_groups_clamped;
    logic [ARW-1:0] n_agents_clamped;

    // round state
    logic [GW-1:0] r_group_cnt;
    logic [AW-1:0] r_agent_cnt;
    logic [IW-1:0] r_run_idx;
    logic [VW-1:0] r_grp_hi_val, r_grp_lo_val, r_best_hi_val, r_best_lo_val;
    logic [IW-1:0] r_grp_hi_idx, r_grp_lo_idx, r_best_hi_idx, r_best_lo_idx;

    logic [VW-1:0] n_grp_hi_val, n_grp_lo_val, n_best_hi_val, n_best_lo_val;
    logic [IW-1:0] n_grp_hi_idx, n_grp_lo_idx, n_best_hi_idx, n_best_lo_idx;

    logic accept;
    logic first_agent, first_group, group_end, run_end;
    logic [1:0] push_cnt;
    gfmmt_pkg::t_record rec_group, rec_global;

    // output queue
    gfmmt_pkg::t_record r_queue [QD];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           pop;
    gfmmt_pkg::t_record head;

    // clamp a register write into its legal range
    always_comb begin
        if (i_cfg_data[GRW-1:0] == '0) begin
            n_groups_clamped = GRW'(1);
        end else if (i_cfg_data[GRW-1:0] > GRW'(gfmmt_pkg::MAX_GROUPS)) begin
            n_groups_clamped = GRW'(gfmmt_pkg::MAX_GROUPS);
        end else begin
            n_groups_clamped = i_cfg_data[GRW-1:0];
        end
        if (i_cfg_data[ARW-1:0] == '0) begin
            n_agents_clamped = ARW'(1);
        end else if (i_cfg_data[ARW-1:0] > ARW'(gfmmt_pkg::MAX_AGENTS)) begin
            n_agents_clamped = ARW'(gfmmt_pkg::MAX_AGENTS);
        end else begin
            n_agents_clamped = i_cfg_data[ARW-1:0];
        end
    end

    assign o_in_ready = (r_count <= (QAW+1)'(QD - 2));
    assign accept     = i_in_valid && o_in_ready;

    // per-group and per-round extremes for the incoming word
    always_comb begin
        first_agent = (r_agent_cnt == '0);
        first_group = (r_group_cnt == '0);
        group_end   = (({1'b0, r_agent_cnt} + ARW'(1)) >= r_agents);
        run_end     = (({1'b0, r_group_cnt} + GRW'(1)) >= r_groups);

        if (first_agent || (i_fitness_value > $signed(r_grp_hi_val))) begin
            n_grp_hi_val = i_fitness_value;
            n_grp_hi_idx = r_run_idx;
        end else begin
            n_grp_hi_val = r_grp_hi_val;
            n_grp_hi_idx = r_grp_hi_idx;
        end
        if (first_agent || ($signed(r_grp_lo_val) > i_fitness_value)) begin
            n_grp_lo_val = i_fitness_value;
            n_grp_lo_idx = r_run_idx;
        end else begin
            n_grp_lo_val = r_grp_lo_val;
            n_grp_lo_idx = r_grp_lo_idx;
        end

        if (first_group || ($signed(n_grp_hi_val) > $signed(r_best_hi_val))) begin
            n_best_hi_val = n_grp_hi_val;
            n_best_hi_idx = n_grp_hi_idx;
        end else begin
            n_best_hi_val = r_best_hi_val;
            n_best_hi_idx = r_best_hi_idx;
        end
        if (first_group || ($signed(r_best_lo_val) > $signed(n_grp_lo_val))) begin
            n_best_lo_val = n_grp_lo_val;
            n_best_lo_idx = n_grp_lo_idx;
        end else begin
            n_best_lo_val = r_best_lo_val;
            n_best_lo_idx = r_best_lo_idx;
        end

        rec_group.kind   = gfmmt_pkg::KIND_GROUP;
        rec_group.group  = r_group_cnt;
        rec_group.hi_idx = n_grp_hi_idx;
        rec_group.hi_val = n_grp_hi_val;
        rec_group.lo_idx = n_grp_lo_idx;
        rec_group.lo_val = n_grp_lo_val;
        rec_group.last   = !run_end;

        rec_global.kind   = gfmmt_pkg::KIND_GLOBAL;
        rec_global.group  = '0;
        rec_global.hi_idx = n_best_hi_idx;
        rec_global.hi_val = n_best_hi_val;
        rec_global.lo_idx = n_best_lo_idx;
        rec_global.lo_val = n_best_lo_val;
        rec_global.last   = 1'b1;

        if (!accept || !group_end) begin
            push_cnt = 2'd0;
        end else if (run_end) begin
            push_cnt = 2'd2;
        end else begin
            push_cnt = 2'd1;
        end
    end

    // configuration and round counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups    <= GRW'(1);
            r_agents    <= ARW'(1);
            r_group_cnt <= '0;
            r_agent_cnt <= '0;
            r_run_idx   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gfmmt_pkg::REG_GROUPS_IN_USE: r_groups <= n_groups_clamped;
                gfmmt_pkg::REG_AGENTS_IN_USE: r_agents <= n_agents_clamped;
                default: ;
            endcase
            r_group_cnt <= '0;
            r_agent_cnt <= '0;
            r_run_idx   <= '0;
        end else if (accept) begin
            if (!group_end) begin
                r_agent_cnt <= r_agent_cnt + AW'(1);
                r_run_idx   <= r_run_idx + IW'(1);
            end else begin
                r_agent_cnt <= '0;
                if (run_end) begin
                    r_group_cnt <= '0;
                    r_run_idx   <= '0;
                end else begin
                    r_group_cnt <= r_group_cnt + GW'(1);
                    r_run_idx   <= r_run_idx + IW'(1);
                end
            end
        end
    end

    // extreme values and indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_hi_val  <= '0;
            r_grp_hi_idx  <= '0;
            r_grp_lo_val  <= '0;
            r_grp_lo_idx  <= '0;
            r_best_hi_val <= '0;
            r_best_hi_idx <= '0;
            r_best_lo_val <= '0;
            r_best_lo_idx <= '0;
        end else if (accept && !i_cfg_we) begin
            r_grp_hi_val <= n_grp_hi_val;
            r_grp_hi_idx <= n_grp_hi_idx;
            r_grp_lo_val <= n_grp_lo_val;
            r_grp_lo_idx <= n_grp_lo_idx;
            if (group_end) begin
                r_best_hi_val <= n_best_hi_val;
                r_best_hi_idx <= n_best_hi_idx;
                r_best_lo_val <= n_best_lo_val;
                r_best_lo_idx <= n_best_lo_idx;
            end
        end
    end

    // output queue control
    assign pop  = o_out_valid && i_out_ready;
    assign head = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wr_ptr <= r_wr_ptr;
                r_count  <= r_count - (QAW+1)'(pop);
            end else begin
                r_wr_ptr <= r_wr_ptr + QAW'(push_cnt);
                r_count  <= r_count + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
        end
    end

    // queue storage: group record first, global record behind it
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            if (!i_cfg_we && (push_cnt != 2'd0) && (QAW'(i) == r_wr_ptr)) begin
                r_queue[i] <= rec_group;
            end
            if (!i_cfg_we && (push_cnt == 2'd2) && (QAW'(i) == r_wr_ptr + QAW'(1))) begin
                r_queue[i] <= rec_global;
            end
        end
    end

    // output word
    assign o_out_valid     = (r_count != '0);
    assign o_record_kind   = head.kind;
    assign o_group_number  = head.group;
    assign o_highest_index = head.hi_idx;
    assign o_highest_value = $signed(head.hi_val);
    assign o_lowest_index  = head.lo_idx;
    assign o_lowest_value  = $signed(head.lo_val);
    assign o_last_of_run   = head.last;

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QD))
        else $error("output queue over capacity");

    // agent counter stays inside the configured group size
    a_agent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_agent_cnt} < r_agents)
        else $error("agent counter beyond group size");

    // group counter stays inside the configured group count
    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_group_cnt} < r_groups)
        else $error("group counter beyond group count");

    // a word that closes the last group queues two records
    a_two_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we && group_end && run_end && !pop)
            |=> (r_count == $past(r_count) + (QAW+1)'(2)))
        else $error("round end did not queue group and global records");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for grouped_fitness_min_max_tracker: drives fitness
// words and size settings, predicts group and global records and checks them.
// Depends on gfmmt_pkg and the tracker top level in src.
`timescale 1ns / 1ps
module tb_top;

    localparam int VW  = gfmmt_pkg::VALUE_W;
    localparam int IW  = gfmmt_pkg::INDEX_W;
    localparam int GW  = gfmmt_pkg::GROUP_W;
    localparam int GRW = gfmmt_pkg::GROUPS_REG_W;
    localparam int ARW = gfmmt_pkg::AGENTS_REG_W;
    localparam int DW  = gfmmt_pkg::CFG_DATA_W;
    localparam int XW  = gfmmt_pkg::CFG_IDX_W;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 10;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int TOTAL_WORDS   = 1180;
    localparam int PHASE_CAP     = 80;
    localparam int IDLE_PERCENT  = 37;

    // directed fitness words
    localparam logic [VW-1:0] LONE_WORDS [4] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };
    localparam logic [VW-1:0] TIE_WORDS [12] = '{
        32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFD, 32'hFFFF_FFFD,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001
    };

    // predicts the records of the tracker and holds the ones still due
    class record_scoreboard;
        logic [GRW-1:0]          groups_reg;
        logic [ARW-1:0]          agents_reg;
        int unsigned             group_count;
        int unsigned             agent_pos;
        logic [IW-1:0]           agent_index;
        logic [VW-1:0]           grp_hi_val, grp_lo_val, best_hi_val, best_lo_val;
        logic [IW-1:0]           grp_hi_idx, grp_lo_idx, best_hi_idx, best_lo_idx;
        gfmmt_pkg::t_record      due_records[$];
        int                      failures;
        int                      records_seen;
        int                      words_seen;

        function new();
            groups_reg   = GRW'(1);
            agents_reg   = ARW'(1);
            group_count  = 0;
            agent_pos    = 0;
            agent_index  = '0;
            grp_hi_val   = '0;
            grp_lo_val   = '0;
            best_hi_val  = '0;
            best_lo_val  = '0;
            grp_hi_idx   = '0;
            grp_lo_idx   = '0;
            best_hi_idx  = '0;
            best_lo_idx  = '0;
            failures     = 0;
            records_seen = 0;
            words_seen   = 0;
        endfunction

        // out-of-range sizes fall back to 1 or to the maximum
        function int unsigned clamp(int unsigned v, int unsigned limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function int unsigned round_length();
            return clamp(groups_reg, gfmmt_pkg::MAX_GROUPS) *
                   clamp(agents_reg, gfmmt_pkg::MAX_AGENTS);
        endfunction

        function int outstanding();
            return due_records.size();
        endfunction

        // any register write restarts the round
        function void write_register(logic [XW-1:0] idx, logic [DW-1:0] data);
            if (idx == gfmmt_pkg::REG_GROUPS_IN_USE)
                groups_reg = data[GRW-1:0];
            else
                agents_reg = data[ARW-1:0];
            group_count = 0;
            agent_pos   = 0;
            agent_index = '0;
        endfunction

        // accepted fitness word: update group and round extremes
        function void note_word(logic [VW-1:0] v);
            int unsigned        groups_eff;
            int unsigned        agents_eff;
            bit                 round_done;
            gfmmt_pkg::t_record rec;
            groups_eff = clamp(groups_reg, gfmmt_pkg::MAX_GROUPS);
            agents_eff = clamp(agents_reg, gfmmt_pkg::MAX_AGENTS);
            words_seen++;

            // first agent opens the group, later ones win only when strictly beyond
            if (agent_pos == 0) begin
                grp_hi_val = v;
                grp_hi_idx = agent_index;
                grp_lo_val = v;
                grp_lo_idx = agent_index;
            end else begin
                if ($signed(v) > $signed(grp_hi_val)) begin
                    grp_hi_val = v;
                    grp_hi_idx = agent_index;
                end
                if ($signed(v) < $signed(grp_lo_val)) begin
                    grp_lo_val = v;
                    grp_lo_idx = agent_index;
                end
            end
            agent_index = agent_index + 1'b1;

            if (agent_pos + 1 < agents_eff) begin
                agent_pos++;
                return;
            end
            agent_pos = 0;

            // fold the closed group into the round extremes, earlier group wins ties
            if (group_count == 0) begin
                best_hi_val = grp_hi_val;
                best_hi_idx = grp_hi_idx;
                best_lo_val = grp_lo_val;
                best_lo_idx = grp_lo_idx;
            end else begin
                if ($signed(grp_hi_val) > $signed(best_hi_val)) begin
                    best_hi_val = grp_hi_val;
                    best_hi_idx = grp_hi_idx;
                end
                if ($signed(grp_lo_val) < $signed(best_lo_val)) begin
                    best_lo_val = grp_lo_val;
                    best_lo_idx = grp_lo_idx;
                end
            end

            round_done = (group_count + 1 >= groups_eff);
            rec.kind   = gfmmt_pkg::KIND_GROUP;
            rec.group  = GW'(group_count);
            rec.hi_idx = grp_hi_idx;
            rec.hi_val = grp_hi_val;
            rec.lo_idx = grp_lo_idx;
            rec.lo_val = grp_lo_val;
            rec.last   = !round_done;
            due_records.push_back(rec);
            if (!round_done) begin
                group_count++;
                return;
            end

            // last group closes the round with a global record
            rec.kind   = gfmmt_pkg::KIND_GLOBAL;
            rec.group  = '0;
            rec.hi_idx = best_hi_idx;
            rec.hi_val = best_hi_val;
            rec.lo_idx = best_lo_idx;
            rec.lo_val = best_lo_val;
            rec.last   = 1'b1;
            due_records.push_back(rec);
            group_count = 0;
            agent_index = '0;
        endfunction

        // compare an accepted record with the oldest one due
        function void check_record(gfmmt_pkg::t_record got);
            gfmmt_pkg::t_record want;
            records_seen++;
            if (due_records.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected record: kind %0d grp %0d hi %0d@%0d lo %0d@%0d last %0d",
                             got.kind, got.group, $signed(got.hi_val), got.hi_idx,
                             $signed(got.lo_val), got.lo_idx, got.last);
                return;
            end
            want = due_records.pop_front();
            if (got.kind !== want.kind || got.group !== want.group ||
                got.hi_idx !== want.hi_idx || got.hi_val !== want.hi_val ||
                got.lo_idx !== want.lo_idx || got.lo_val !== want.lo_val ||
                got.last !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display({"record %0d mismatch: expected kind %0d grp %0d hi %0d@%0d ",
                              "lo %0d@%0d last %0d, got kind %0d grp %0d hi %0d@%0d ",
                              "lo %0d@%0d last %0d"},
                             records_seen, want.kind, want.group, $signed(want.hi_val),
                             want.hi_idx, $signed(want.lo_val), want.lo_idx, want.last,
                             got.kind, got.group, $signed(got.hi_val), got.hi_idx,
                             $signed(got.lo_val), got.lo_idx, got.last);
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [XW-1:0]              cfg_index;
    logic [DW-1:0]              cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [VW-1:0]       fitness;
    logic                       out_valid;
    logic                       out_ready;
    logic                       record_kind;
    logic [GW-1:0]              group_number;
    logic [IW-1:0]              highest_index;
    logic signed [VW-1:0]       highest_value;
    logic [IW-1:0]              lowest_index;
    logic signed [VW-1:0]       lowest_value;
    logic                       last_of_run;

    record_scoreboard   tracker = new();
    gfmmt_pkg::t_record seen_record;
    bit                 steady       = 1'b0;
    bit                 hold_request = 1'b0;
    int                 cycle_count  = 0;
    int                 settings     = 0;

    grouped_fitness_min_max_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_fitness_value (fitness),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_record_kind   (record_kind),
        .o_group_number  (group_number),
        .o_highest_index (highest_index),
        .o_highest_value (highest_value),
        .o_lowest_index  (lowest_index),
        .o_lowest_value  (lowest_value),
        .o_last_of_run   (last_of_run)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // output record as seen on the ports
    always_comb begin
        seen_record.kind   = gfmmt_pkg::t_kind'(record_kind);
        seen_record.group  = group_number;
        seen_record.hi_idx = highest_index;
        seen_record.hi_val = highest_value;
        seen_record.lo_idx = lowest_index;
        seen_record.lo_val = lowest_value;
        seen_record.last   = last_of_run;
    end

    // record checking on accepted output words
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            tracker.check_record(seen_record);
    end

    // receiver: random back-pressure, long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // offer one fitness word, called and returning at a falling edge
    task automatic send_fitness(input logic [VW-1:0] v);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        fitness  <= v;
        do @(posedge i_clk); while (!in_ready);
        tracker.note_word(v);
        @(negedge i_clk);
    endtask

    // stop offering, wait for every due record plus the queue latency
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (tracker.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write both size registers back to back
    task automatic set_sizes(input logic [DW-1:0] groups_data,
                             input logic [DW-1:0] agents_data);
        cfg_we    <= 1'b1;
        cfg_index <= gfmmt_pkg::REG_GROUPS_IN_USE;
        cfg_data  <= groups_data;
        @(posedge i_clk);
        tracker.write_register(gfmmt_pkg::REG_GROUPS_IN_USE, groups_data);
        @(negedge i_clk);
        cfg_index <= gfmmt_pkg::REG_AGENTS_IN_USE;
        cfg_data  <= agents_data;
        @(posedge i_clk);
        tracker.write_register(gfmmt_pkg::REG_AGENTS_IN_USE, agents_data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // one size setting followed by whole rounds of random words and a tail, within a cap
    task automatic run_phase(input logic [DW-1:0] groups_data,
                             input logic [DW-1:0] agents_data,
                             input int rounds, input int extra, input bit pause,
                             input bit squeeze, output int words);
        int              k;
        int              pause_at;
        logic [VW-1:0]   v;
        settle();
        set_sizes(groups_data, agents_data);
        words = tracker.round_length() * rounds + extra;
        // a long unsqueezed single round with a short tail runs whole, other long phases are capped
        if (words > PHASE_CAP && (squeeze || rounds != 1 || extra >= 8))
            words = PHASE_CAP;
        pause_at = pause ? $urandom_range(0, words - 1) : -1;
        @(posedge i_clk);
        steady       = squeeze;
        hold_request = squeeze;
        @(negedge i_clk);
        for (k = 0; k < words; k++) begin
            // sender pause until the block has drained
            if (k == pause_at) begin
                in_valid <= 1'b0;
                do @(negedge i_clk); while (tracker.outstanding() != 0);
            end
            case ($urandom_range(0, 9))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2, 3:    v = $urandom_range(0, 6) - 3;
                default: v = $urandom();
            endcase
            send_fitness(v);
        end
    endtask

    // stimulus
    initial begin
        int              k;
        int              words;
        int              random_words;
        logic [DW-1:0]   groups_data;
        logic [DW-1:0]   agents_data;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        fitness   = '0;
        random_words = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: every word is a whole round
        for (k = 0; k < 4; k++)
            send_fitness(LONE_WORDS[k]);

        // three groups of four: ties inside a group and across groups
        settle();
        set_sizes(11'd3, 11'd4);
        for (k = 0; k < 12; k++)
            send_fitness(TIE_WORDS[k]);

        // zero sizes count as one, upper data bits of the group register ignored
        settle();
        set_sizes(11'h7E0, 11'h000);
        send_fitness(32'h1234_5678);
        send_fitness(32'hEDCB_A988);

        // open group cut short by the next register write
        settle();
        set_sizes(11'd2, 11'd3);
        send_fitness(32'h0000_0100);
        send_fitness(32'hFFFF_FF00);

        // oversized group count clamps to sixteen; output held off to fill the queue
        run_phase(11'h7FF, 11'd1, 3, 0, 1'b0, 1'b1, words);

        // oversized agent count clamps to the maximum group length
        run_phase(11'd1, 11'h7FF, 1, 3, 1'b0, 1'b0, words);

        // random size settings, mostly short rounds
        while (tracker.words_seen < TOTAL_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: agents_data = DW'($urandom_range(0, 6));
                6, 7, 8:          agents_data = DW'($urandom_range(7, 24));
                default:          agents_data = DW'($urandom_range(25, 80));
            endcase
            groups_data[DW-1:GRW] = (DW-GRW)'($urandom_range(0, 63));
            groups_data[GRW-1:0] = (agents_data > 6) ? GRW'($urandom_range(0, 3))
                                                     : GRW'($urandom_range(0, 31));
            run_phase(groups_data, agents_data, $urandom_range(1, 3),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0,
                      (random_words == 0) || ($urandom_range(0, 5) == 0),
                      1'b0, words);
            random_words += words;
        end

        // final drain
        in_valid <= 1'b0;
        k = 0;
        while (tracker.outstanding() != 0 && k < DRAIN_LIMIT) begin
            @(negedge i_clk);
            k++;
        end
        repeat (END_CYCLES) @(negedge i_clk);
        if (tracker.outstanding() != 0) begin
            $display("%0d records never arrived", tracker.outstanding());
            tracker.failures += tracker.outstanding();
        end

        $display("run summary: %0d fitness words over %0d size settings, %0d records compared",
                 tracker.words_seen, settings, tracker.records_seen);
        $display("covered ties, clamped sizes, 1024-agent groups, mid-group restart, stalls");
        if (tracker.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gfmmt_pkg.sv
src/grouped_fitness_min_max_tracker.sv
test/tb_top.sv
